>>> sv/ds_twr_pkg.sv
// ----------------------------------------------------------------------------
// ds_twr_pkg
// Shared types, codes and frame tables of the two-way ranging initiator.
// ----------------------------------------------------------------------------
package ds_twr_pkg;

    localparam int unsigned HEADER_LEN = 10;
    localparam int unsigned MAX_FRAME  = 20;
    localparam int unsigned POLL_LEN   = 10;
    localparam int unsigned FINAL_LEN  = 22;
    localparam int unsigned SEQ_POS    = 2;

    localparam int unsigned IDX_W = $clog2(FINAL_LEN);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_RESP = 2'd1,
        PH_SEND = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        MODE_START     = 3'd0,
        MODE_RESP_BYTE = 3'd1,
        MODE_TIMEOUT   = 3'd2,
        MODE_RX_ERROR  = 3'd3,
        MODE_SEND_DONE = 3'd4,
        MODE_LATE      = 3'd5
    } mode_t;

    typedef enum logic [2:0] {
        OC_OK       = 3'd0,
        OC_SEND_ERR = 3'd1,
        OC_LATE     = 3'd2,
        OC_MISMATCH = 3'd3,
        OC_TIMEOUT  = 3'd4,
        OC_RX_ERR   = 3'd5
    } outcome_t;

    typedef enum logic [1:0] {
        BK_POLL   = 2'd0,
        BK_FINAL  = 2'd1,
        BK_REPORT = 2'd2
    } burst_kind_t;

    typedef enum logic {
        CFG_TX_ANT_DELAY  = 1'b0,
        CFG_FINAL_DELAY   = 1'b1
    } cfg_index_t;

    localparam logic [15:0] TX_ANT_DELAY_RST = 16'd16385;
    localparam logic [15:0] FINAL_DELAY_RST  = 16'd2400;

    function automatic logic [7:0] resp_hdr_byte(input logic [3:0] i);
        logic [7:0] b;
        case (i)
            4'd0:    b = 8'h41;
            4'd1:    b = 8'h88;
            4'd2:    b = 8'h00;
            4'd3:    b = 8'hCA;
            4'd4:    b = 8'hDE;
            4'd5:    b = 8'h56;
            4'd6:    b = 8'h45;
            4'd7:    b = 8'h57;
            4'd8:    b = 8'h41;
            4'd9:    b = 8'h10;
            4'd10:   b = 8'h02;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // poll and final headers differ only in the function code byte
    function automatic logic [7:0] frame_head_byte(input logic [3:0] i, input logic fin);
        logic [7:0] b;
        case (i)
            4'd0:    b = 8'h41;
            4'd1:    b = 8'h88;
            4'd3:    b = 8'hCA;
            4'd4:    b = 8'hDE;
            4'd5:    b = 8'h57;
            4'd6:    b = 8'h41;
            4'd7:    b = 8'h56;
            4'd8:    b = 8'h45;
            4'd9:    b = fin ? 8'h23 : 8'h21;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

>>> sv/ds_twr_initiator_sequencer.sv
// ----------------------------------------------------------------------------
// ds_twr_initiator_sequencer
// Initiator sequencer for double-sided two-way ranging: poll, response check,
// final frame and outcome reports.
// ----------------------------------------------------------------------------
// Every request is decoded combinationally against the phase state. Requests
// that give no result (response bytes before the last, events in the wrong
// phase) are taken every cycle, even while a frame drains. A request that gives
// results loads the output burst register, which then presents one result per
// cycle while out_stall is low: 10 results for a poll frame, 22 for a final
// frame, 1 for a report. The next result-producing request is taken in the
// cycle the last result of the current burst is taken; until then it is stalled.
module ds_twr_initiator_sequencer
    import ds_twr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  mode,
    input  logic [7:0]  rx_byte,
    input  logic        rx_last,
    input  logic [39:0] poll_sent_time,
    input  logic [39:0] resp_arrival_time,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        item_kind,
    output logic [7:0]  tx_byte,
    output logic        frame_end,
    output logic        delayed_launch,
    output logic [31:0] launch_time,
    output logic [2:0]  outcome,
    output logic [7:0]  sequence_res
);

    logic [15:0]      tx_ant_delay_reg;
    logic [15:0]      final_delay_reg;

    phase_t           phase_reg, phase_next;
    logic [7:0]       seq_reg, seq_next;
    logic [7:0]       rx_count_reg, rx_count_next;
    logic             mismatch_reg, mismatch_next;

    logic             burst_valid_reg;
    burst_kind_t      kind_reg, kind_next;
    logic [IDX_W-1:0] idx_reg;
    logic [7:0]       seq_res_reg, seq_res_next;
    outcome_t         oc_reg, oc_next;
    logic [31:0]      poll_ts_reg;
    logic [31:0]      resp_ts_reg;
    logic [31:0]      lt_reg, lt_next;

    logic             gives;
    logic             accept;
    logic             out_take;
    logic             burst_done;
    logic [IDX_W-1:0] last_idx;
    logic [39:0]      launch_sum;
    logic [7:0]       rx_inc;
    logic             hdr_bad;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_ant_delay_reg <= TX_ANT_DELAY_RST;
            final_delay_reg  <= FINAL_DELAY_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_TX_ANT_DELAY: tx_ant_delay_reg <= cfg_data;
                CFG_FINAL_DELAY:  final_delay_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    // ---------------- request decode ----------------
    assign launch_sum = resp_arrival_time + {8'd0, final_delay_reg, 16'd0};
    assign rx_inc     = (rx_count_reg == 8'hFF) ? rx_count_reg : rx_count_reg + 8'd1;
    assign hdr_bad    = (rx_count_reg < 8'(HEADER_LEN)) && (rx_count_reg != 8'(SEQ_POS))
                        && (rx_byte != resp_hdr_byte(rx_count_reg[3:0]));

    always_comb
    begin
        phase_next    = phase_reg;
        seq_next      = seq_reg;
        rx_count_next = rx_count_reg;
        mismatch_next = mismatch_reg;
        gives         = 1'b0;
        kind_next     = BK_REPORT;
        oc_next       = OC_OK;
        seq_res_next  = seq_reg;
        lt_next       = launch_sum[39:8];

        if (mode_t'(mode) == MODE_START)
        begin
            gives         = 1'b1;
            kind_next     = BK_POLL;
            seq_next      = seq_reg + 8'd1;
            seq_res_next  = seq_reg + 8'd1;
            phase_next    = PH_RESP;
            rx_count_next = 8'd0;
            mismatch_next = 1'b0;
        end
        else if (phase_reg == PH_RESP)
        begin
            case (mode_t'(mode))
                MODE_RESP_BYTE:
                begin
                    rx_count_next = rx_inc;
                    mismatch_next = mismatch_reg | hdr_bad | (rx_inc > 8'(MAX_FRAME));
                    if (rx_last)
                    begin
                        gives = 1'b1;
                        if (mismatch_next || (rx_inc < 8'(HEADER_LEN)))
                        begin
                            mismatch_next = 1'b1;
                            oc_next       = OC_MISMATCH;
                            phase_next    = PH_IDLE;
                        end
                        else
                        begin
                            kind_next    = BK_FINAL;
                            seq_next     = seq_reg + 8'd1;
                            seq_res_next = seq_reg + 8'd1;
                            phase_next   = PH_SEND;
                        end
                    end
                end
                MODE_TIMEOUT:
                begin
                    gives      = 1'b1;
                    oc_next    = OC_TIMEOUT;
                    phase_next = PH_IDLE;
                end
                MODE_RX_ERROR:
                begin
                    gives      = 1'b1;
                    oc_next    = OC_RX_ERR;
                    phase_next = PH_IDLE;
                end
                default: ;
            endcase
        end
        else if (phase_reg == PH_SEND)
        begin
            case (mode_t'(mode))
                MODE_SEND_DONE:
                begin
                    gives      = 1'b1;
                    oc_next    = OC_OK;
                    phase_next = PH_IDLE;
                end
                MODE_LATE:
                begin
                    gives      = 1'b1;
                    oc_next    = OC_LATE;
                    phase_next = PH_IDLE;
                end
                MODE_TIMEOUT, MODE_RX_ERROR:
                begin
                    gives      = 1'b1;
                    oc_next    = OC_SEND_ERR;
                    phase_next = PH_IDLE;
                end
                default: ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    always_comb
    begin
        unique case (kind_reg)
            BK_POLL:  last_idx = IDX_W'(POLL_LEN - 1);
            BK_FINAL: last_idx = IDX_W'(FINAL_LEN - 1);
            default:  last_idx = '0;
        endcase
    end

    assign out_valid  = burst_valid_reg;
    assign frame_end  = (idx_reg == last_idx);
    assign out_take   = out_valid && !out_stall;
    assign burst_done = out_take && frame_end;
    assign in_stall   = gives && burst_valid_reg && !burst_done;
    assign accept     = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            seq_reg         <= 8'd0;
            rx_count_reg    <= 8'd0;
            mismatch_reg    <= 1'b0;
            burst_valid_reg <= 1'b0;
            kind_reg        <= BK_REPORT;
            idx_reg         <= '0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg    <= phase_next;
                seq_reg      <= seq_next;
                rx_count_reg <= rx_count_next;
                mismatch_reg <= mismatch_next;
            end
            if (accept && gives)
            begin
                burst_valid_reg <= 1'b1;
                kind_reg        <= kind_next;
                idx_reg         <= '0;
            end
            else if (burst_done)
            begin
                burst_valid_reg <= 1'b0;
            end
            else if (out_take)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && gives)
        begin
            seq_res_reg <= seq_res_next;
            oc_reg      <= oc_next;
            poll_ts_reg <= poll_sent_time[31:0];
            resp_ts_reg <= resp_arrival_time[31:0];
            lt_reg      <= lt_next;
        end
    end

    // ---------------- result byte select ----------------
    logic [31:0]      final_stamp;
    logic [IDX_W-1:0] rel_idx;
    logic [7:0]       frame_byte;

    assign final_stamp = {lt_reg[23:1], 1'b0, 8'd0} + {16'd0, tx_ant_delay_reg};
    assign rel_idx     = idx_reg - IDX_W'(POLL_LEN);

    always_comb
    begin
        case (idx_reg) inside
            [0:9]:
            begin
                if (idx_reg == IDX_W'(SEQ_POS))
                    frame_byte = seq_res_reg - 8'd1;
                else
                    frame_byte = frame_head_byte(idx_reg[3:0], kind_reg == BK_FINAL);
            end
            [10:13]: frame_byte = poll_ts_reg[8*rel_idx[1:0] +: 8];
            [14:17]: frame_byte = resp_ts_reg[8*rel_idx[1:0] +: 8];
            default: frame_byte = final_stamp[8*rel_idx[1:0] +: 8];
        endcase
    end

    assign item_kind      = (kind_reg == BK_REPORT);
    assign tx_byte        = item_kind ? 8'd0 : frame_byte;
    assign delayed_launch = (kind_reg == BK_FINAL);
    assign launch_time    = delayed_launch ? lt_reg : 32'd0;
    assign outcome        = item_kind ? oc_reg : OC_OK;
    assign sequence_res   = seq_res_reg;

    // ---------------- assertions ----------------
    a_stall_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no burst pending");

    a_report_single: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind_reg == BK_REPORT) |-> (idx_reg == '0))
        else $error("report burst advanced past its only result");

    a_idx_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !frame_end) |=>
            (out_valid && idx_reg == $past(idx_reg) + IDX_W'(1)))
        else $error("burst index did not advance on a taken result");

    a_final_in_send: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind_reg == BK_FINAL) |-> (phase_reg == PH_SEND))
        else $error("final frame draining outside send phase");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (idx_reg <= last_idx))
        else $error("burst index past frame length");

endmodule
